FILE: hdl/nfa_epsilon_acceptor_top_assert.svh
// assertion macros for the nfa epsilon acceptor
`ifndef NFA_EPSILON_ACCEPTOR_TOP_ASSERT_SVH
`define NFA_EPSILON_ACCEPTOR_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clk and disabled in reset
`define NFA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk and disabled in reset
`define NFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define NFA_ASSERT_IMPL(lbl, ante, cons, msg)
`define NFA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hdl/nfa_eps_pkg.sv
// shared constants, types and helpers for the nfa epsilon acceptor
package nfa_eps_pkg;

    // automaton size
    localparam int MAX_STATES      = 16;
    localparam int SLOTS_PER_STATE = 8;
    localparam int TABLE_DEPTH     = MAX_STATES * SLOTS_PER_STATE;

    // derived widths
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int SRC_W  = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int SLOT_W = (SLOTS_PER_STATE > 1) ? $clog2(SLOTS_PER_STATE) : 1;

    // fixed field widths
    localparam int CMD_W    = 2;
    localparam int STATE_FW = 4;
    localparam int SLOT_FW  = 3;
    localparam int SYM_W    = 8;

    // edge label that marks an epsilon move
    localparam logic [SYM_W-1:0] EPSILON_SYMBOL = 8'd38;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_SLOT = 2'd0,
        CMD_SET_ACCEPT = 2'd1,
        CMD_SYMBOL     = 2'd2,
        CMD_END        = 2'd3
    } cmd_t;

    typedef logic [MAX_STATES-1:0] set_t;

    // write request into the edge table
    typedef struct packed {
        logic                en;
        logic [ADDR_W-1:0]   addr;
        logic                vld;
        logic [SYM_W-1:0]    symbol;
        logic [STATE_FW-1:0] target;
    } table_wr_t;

    // registered read data from the edge table
    typedef struct packed {
        logic                vld;
        logic [SYM_W-1:0]    symbol;
        logic [STATE_FW-1:0] target;
    } table_rd_t;

    // one-hot set bit for a state, empty when the state is out of range
    function automatic set_t state_bit(input logic [STATE_FW-1:0] s);
        set_t b;
        b = '0;
        for (int i = 0; i < MAX_STATES; i++) begin
            b[i] = (int'(s) == i);
        end
        return b;
    endfunction

endpackage

FILE: hdl/nfa_eps_if.sv
// channel interfaces: input item, result item and configuration write

interface nfa_eps_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [3:0] state_sel;
    logic [2:0] slot_sel;
    logic       slot_valid;
    logic [7:0] edge_symbol;
    logic [3:0] target_state;
    logic       accept_flag;
    logic [7:0] in_symbol;

    modport source (
        output valid, cmd, state_sel, slot_sel, slot_valid, edge_symbol,
               target_state, accept_flag, in_symbol,
        input  ready
    );
    modport sink (
        input  valid, cmd, state_sel, slot_sel, slot_valid, edge_symbol,
               target_state, accept_flag, in_symbol,
        output ready
    );
endinterface

interface nfa_eps_result_if;
    logic valid;
    logic ready;
    logic accepted;
    logic no_active;

    modport source (output valid, accepted, no_active, input ready);
    modport sink (input valid, accepted, no_active, output ready);
endinterface

interface nfa_eps_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] start_state;

    modport source (output valid, start_state, input ready);
    modport sink (input valid, start_state, output ready);
endinterface

FILE: hdl/nfa_eps_table.sv
// edge table memory with per-slot valid flags and registered read port
module nfa_eps_table (
    input  logic                            clk,
    input  logic                            rst_n,
    input  nfa_eps_pkg::table_wr_t          wr,
    input  logic [nfa_eps_pkg::ADDR_W-1:0]  rd_addr,
    output nfa_eps_pkg::table_rd_t          rd
);

    logic [nfa_eps_pkg::SYM_W-1:0]    sym_mem    [nfa_eps_pkg::TABLE_DEPTH];
    logic [nfa_eps_pkg::STATE_FW-1:0] tgt_mem    [nfa_eps_pkg::TABLE_DEPTH];
    logic [nfa_eps_pkg::TABLE_DEPTH-1:0] vld_reg;
    logic [nfa_eps_pkg::SYM_W-1:0]    rd_sym_reg;
    logic [nfa_eps_pkg::STATE_FW-1:0] rd_tgt_reg;
    logic                             rd_vld_reg;

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            sym_mem[wr.addr] <= wr.symbol;
            tgt_mem[wr.addr] <= wr.target;
        end
        rd_sym_reg <= sym_mem[rd_addr];
        rd_tgt_reg <= tgt_mem[rd_addr];
    end

    // slot valid flags, all invalid after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= wr.vld;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign rd = '{vld: rd_vld_reg, symbol: rd_sym_reg, target: rd_tgt_reg};

endmodule

FILE: hdl/nfa_epsilon_acceptor_top.sv
// nfa epsilon acceptor: sequencer, table sweeps and result register
// load items complete on transfer; a table sweep reads one slot a cycle over all TABLE_DEPTH slots
// a symbol item: transfer, one follow sweep, closure sweeps until one adds nothing; epsilon clears the set
// the first symbol or end item of a string first runs the start-state closure sweeps
// an armed end item is judged into the result register once it is free, held while the result is unread
// reset clears the slot valid flags, accepting marks, active set and start state at once
`include "nfa_epsilon_acceptor_top_assert.svh"

module nfa_epsilon_acceptor_top (
    input  logic      clk,
    input  logic      rst_n,
    nfa_eps_cfg_if.sink       cfg,
    nfa_eps_item_if.sink      item,
    nfa_eps_result_if.source  result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FOLLOW,
        ST_CLOSE,
        ST_DONE
    } state_t;

    state_t                               state_reg;
    nfa_eps_pkg::set_t                    active_reg;
    nfa_eps_pkg::set_t                    next_set_reg;
    nfa_eps_pkg::set_t                    marks_reg;
    logic                                 open_reg;
    logic                                 follow_pending_reg;
    logic                                 is_end_reg;
    logic                                 changed_reg;
    logic [nfa_eps_pkg::SYM_W-1:0]        sym_reg;
    logic [nfa_eps_pkg::STATE_FW-1:0]     start_state_reg;
    logic [nfa_eps_pkg::CNT_W-1:0]        cnt_reg;
    logic [nfa_eps_pkg::SRC_W-1:0]        src_reg;
    logic [nfa_eps_pkg::SLOT_W-1:0]       slot_reg;
    logic                                 rd_live_reg;
    logic [nfa_eps_pkg::SRC_W-1:0]        rd_src_reg;
    logic                                 out_valid_reg;
    logic                                 accepted_reg;
    logic                                 no_active_reg;

    nfa_eps_pkg::cmd_t                    item_cmd;
    logic                                 item_xfer;
    logic                                 sel_in_range;
    nfa_eps_pkg::set_t                    sel_bit;
    nfa_eps_pkg::table_wr_t               tbl_wr;
    nfa_eps_pkg::table_rd_t               tbl_rd;
    logic                                 sweeping;
    logic                                 issue;
    logic                                 sweep_end;
    logic [nfa_eps_pkg::SYM_W-1:0]        cmp_sym;
    logic                                 edge_hit;
    nfa_eps_pkg::set_t                    tgt_bit;
    logic                                 judge;

    // handshakes
    assign cfg.ready     = 1'b1;
    assign item.ready    = (state_reg == ST_IDLE);
    assign item_xfer     = item.valid && item.ready;
    assign item_cmd      = nfa_eps_pkg::cmd_t'(item.cmd);
    assign result.valid     = out_valid_reg;
    assign result.accepted  = accepted_reg;
    assign result.no_active = no_active_reg;

    // string judged once the result register is free
    assign judge = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);

    // table write request for slot loads
    assign sel_in_range = (int'(item.state_sel) < nfa_eps_pkg::MAX_STATES);
    assign sel_bit      = nfa_eps_pkg::state_bit(item.state_sel);

    always_comb
    begin
        tbl_wr.en     = item_xfer && (item_cmd == nfa_eps_pkg::CMD_WRITE_SLOT) && sel_in_range
                        && (int'(item.slot_sel) < nfa_eps_pkg::SLOTS_PER_STATE);
        tbl_wr.addr   = nfa_eps_pkg::ADDR_W'(int'(item.state_sel) * nfa_eps_pkg::SLOTS_PER_STATE
                                             + int'(item.slot_sel));
        tbl_wr.vld    = item.slot_valid;
        tbl_wr.symbol = item.edge_symbol;
        tbl_wr.target = item.target_state;
    end

    nfa_eps_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (tbl_wr),
        .rd_addr (cnt_reg[nfa_eps_pkg::ADDR_W-1:0]),
        .rd      (tbl_rd)
    );

    // sweep control and the shared edge compare
    assign sweeping  = (state_reg == ST_FOLLOW) || (state_reg == ST_CLOSE);
    assign issue     = sweeping && (cnt_reg < nfa_eps_pkg::CNT_W'(nfa_eps_pkg::TABLE_DEPTH));
    assign sweep_end = sweeping && !issue && !rd_live_reg;
    assign cmp_sym   = (state_reg == ST_FOLLOW) ? sym_reg : nfa_eps_pkg::EPSILON_SYMBOL;
    assign edge_hit  = rd_live_reg && tbl_rd.vld && (tbl_rd.symbol == cmp_sym)
                       && active_reg[rd_src_reg];
    assign tgt_bit   = nfa_eps_pkg::state_bit(tbl_rd.target);

    // sequencer, sets and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            active_reg         <= '0;
            next_set_reg       <= '0;
            marks_reg          <= '0;
            open_reg           <= 1'b0;
            follow_pending_reg <= 1'b0;
            is_end_reg         <= 1'b0;
            changed_reg        <= 1'b0;
            sym_reg            <= '0;
            start_state_reg    <= '0;
            cnt_reg            <= '0;
            src_reg            <= '0;
            slot_reg           <= '0;
            rd_live_reg        <= 1'b0;
            rd_src_reg         <= '0;
            out_valid_reg      <= 1'b0;
            accepted_reg       <= 1'b0;
            no_active_reg      <= 1'b0;
        end
        else
        begin
            // configuration write
            if (cfg.valid && cfg.ready)
            begin
                start_state_reg <= cfg.start_state;
            end

            // result register: loaded when a string is judged, cleared on transfer
            if (judge)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // slot address walk, one read a cycle
            rd_live_reg <= issue;
            rd_src_reg  <= src_reg;
            if (issue)
            begin
                cnt_reg <= cnt_reg + nfa_eps_pkg::CNT_W'(1);
                if (slot_reg == nfa_eps_pkg::SLOT_W'(nfa_eps_pkg::SLOTS_PER_STATE - 1))
                begin
                    slot_reg <= '0;
                    src_reg  <= src_reg + nfa_eps_pkg::SRC_W'(1);
                end
                else
                begin
                    slot_reg <= slot_reg + nfa_eps_pkg::SLOT_W'(1);
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_xfer)
                    begin
                        unique case (item_cmd)
                            nfa_eps_pkg::CMD_WRITE_SLOT:
                            begin
                                // table write goes through the write request
                            end
                            nfa_eps_pkg::CMD_SET_ACCEPT:
                            begin
                                if (item.accept_flag)
                                    marks_reg <= marks_reg | sel_bit;
                                else
                                    marks_reg <= marks_reg & ~sel_bit;
                            end
                            nfa_eps_pkg::CMD_SYMBOL,
                            nfa_eps_pkg::CMD_END:
                            begin
                                sym_reg    <= item.in_symbol;
                                is_end_reg <= (item_cmd == nfa_eps_pkg::CMD_END);
                                cnt_reg     <= '0;
                                src_reg     <= '0;
                                slot_reg    <= '0;
                                changed_reg <= 1'b0;
                                next_set_reg <= '0;
                                if (!open_reg)
                                begin
                                    // arm with the start-state closure
                                    active_reg         <= nfa_eps_pkg::state_bit(start_state_reg);
                                    open_reg           <= 1'b1;
                                    follow_pending_reg <= (item_cmd == nfa_eps_pkg::CMD_SYMBOL);
                                    state_reg          <= ST_CLOSE;
                                end
                                else if (item_cmd == nfa_eps_pkg::CMD_END)
                                begin
                                    state_reg <= ST_DONE;
                                end
                                else if (item.in_symbol == nfa_eps_pkg::EPSILON_SYMBOL)
                                begin
                                    active_reg <= '0;
                                end
                                else
                                begin
                                    state_reg <= ST_FOLLOW;
                                end
                            end
                        endcase
                    end
                end

                ST_FOLLOW:
                begin
                    if (edge_hit)
                    begin
                        next_set_reg <= next_set_reg | tgt_bit;
                    end
                    if (sweep_end)
                    begin
                        active_reg  <= next_set_reg;
                        cnt_reg     <= '0;
                        src_reg     <= '0;
                        slot_reg    <= '0;
                        changed_reg <= 1'b0;
                        state_reg   <= ST_CLOSE;
                    end
                end

                ST_CLOSE:
                begin
                    // grow the set in place along epsilon edges
                    if (edge_hit && ((active_reg & tgt_bit) == '0))
                    begin
                        active_reg  <= active_reg | tgt_bit;
                        changed_reg <= 1'b1;
                    end
                    if (sweep_end)
                    begin
                        cnt_reg     <= '0;
                        src_reg     <= '0;
                        slot_reg    <= '0;
                        changed_reg <= 1'b0;
                        if (changed_reg)
                        begin
                            state_reg <= ST_CLOSE;
                        end
                        else if (follow_pending_reg)
                        begin
                            follow_pending_reg <= 1'b0;
                            next_set_reg       <= '0;
                            if (sym_reg == nfa_eps_pkg::EPSILON_SYMBOL)
                            begin
                                active_reg <= '0;
                                state_reg  <= ST_IDLE;
                            end
                            else
                            begin
                                state_reg <= ST_FOLLOW;
                            end
                        end
                        else if (is_end_reg)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end

                ST_DONE:
                begin
                    // judge the string once the result register is free
                    if (judge)
                    begin
                        accepted_reg  <= |(active_reg & marks_reg);
                        no_active_reg <= (active_reg == '0);
                        active_reg    <= '0;
                        open_reg      <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    // checks on the sequencer
    `NFA_ASSERT_IMPL(a_done_armed, state_reg == ST_DONE, open_reg,
        "result judged on a string that was never armed")
    `NFA_ASSERT_IMPL(a_pending_in_close, follow_pending_reg, state_reg == ST_CLOSE,
        "pending follow outside the arming closure")
    `NFA_ASSERT_NEXT(a_arm_opens,
        item_xfer && !open_reg
            && (item_cmd == nfa_eps_pkg::CMD_SYMBOL || item_cmd == nfa_eps_pkg::CMD_END),
        open_reg, "symbol or end transfer did not arm the string")
    `NFA_ASSERT_IMPL(a_closed_empty, state_reg == ST_IDLE && !open_reg, active_reg == '0,
        "active states left over after the string closed")
    `NFA_ASSERT_IMPL(a_read_in_sweep, rd_live_reg,
        state_reg == ST_FOLLOW || state_reg == ST_CLOSE,
        "table read data arrived outside a sweep")

endmodule
